// ===== hdl/ptrm_pkg.sv =====
// shared types and constants for the page table range mapper
`timescale 1ns / 1ps
package ptrm_pkg;
    localparam int TABLE_FRAMES = 64;
    localparam int FRAME_W = $clog2(TABLE_FRAMES);
    localparam int CNT_W = $clog2(TABLE_FRAMES + 1);
    localparam int STORE_AW = FRAME_W + 9;
    localparam int STORE_DEPTH = TABLE_FRAMES * 512;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_ADDR = 3'd1;
    localparam logic [2:0] ST_LEN = 3'd2;
    localparam logic [2:0] ST_HUGE = 3'd3;
    localparam logic [2:0] ST_MAPPED = 3'd4;
    localparam logic [2:0] ST_POOL = 3'd5;

    localparam logic [0:0] CFG_HUGE = 1'd0;
    localparam logic [0:0] CFG_BASE = 1'd1;

    typedef struct packed {
        logic [47:0] virt_addr;
        logic [51:0] phys_addr;
        logic [47:0] length_bytes;
        logic [11:0] prot_bits;
        logic        ovw_en;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [36:0] chunks_done;
        logic [47:0] fault_addr;
        logic        tlb_flush_needed;
    } rsp_t;

    // classified job handed from front to back
    typedef struct packed {
        req_t       req;
        logic       pre_fault;
        logic [2:0] pre_status;
    } job_t;
endpackage

// ===== hdl/ptrm_req_if.sv =====
// valid/ready channel carrying a map request
`timescale 1ns / 1ps
interface ptrm_req_if;
    import ptrm_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/ptrm_rsp_if.sv =====
// valid/ready channel carrying a map result
`timescale 1ns / 1ps
interface ptrm_rsp_if;
    import ptrm_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/ptrm_front.sv =====
// request intake, alignment checks and two-entry job queue
`timescale 1ns / 1ps
module ptrm_front
    import ptrm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ptrm_req_if.sink req,
    output logic job_valid,
    input  logic job_ready,
    output job_t job
);
    job_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic rd_reg, wr_reg;
    logic push, pop;
    job_t j;

    always_comb
    begin
        j.req = req.data;
        j.pre_fault = 1'b1;
        j.pre_status = ST_OK;
        if (req.data.virt_addr[11:0] != 12'd0 || req.data.phys_addr[11:0] != 12'd0)
            j.pre_status = ST_ADDR;
        else if (req.data.length_bytes[11:0] != 12'd0)
            j.pre_status = ST_LEN;
        else if (req.data.length_bytes == 48'd0)
            j.pre_status = ST_OK;
        else
            j.pre_fault = 1'b0;
    end

    assign req.ready = cnt_reg != 2'd2;
    assign push = req.valid && req.ready;
    assign job_valid = cnt_reg != 2'd0;
    assign pop = job_valid && job_ready;
    assign job = q_reg[rd_reg];
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push) wr_reg <= ~wr_reg;
            if (pop) rd_reg <= ~rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) q_reg[wr_reg] <= j;
    end
endmodule

// ===== hdl/ptrm_back.sv =====
// table walker with the page-table store, frame allocator and result register
`timescale 1ns / 1ps
module ptrm_back
    import ptrm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic job_valid,
    output logic job_ready,
    input  job_t job,
    input  logic huge_en,
    input  logic [51:0] pool_base,
    ptrm_rsp_if.source rsp
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INIT = 4'd1;
    localparam logic [3:0] S_CHUNK = 4'd2;
    localparam logic [3:0] S_RD = 4'd3;
    localparam logic [3:0] S_WAIT = 4'd4;
    localparam logic [3:0] S_EVAL = 4'd5;
    localparam logic [3:0] S_CLR = 4'd6;
    localparam logic [3:0] S_LEAF = 4'd7;
    localparam logic [3:0] S_OUT = 4'd8;
    localparam logic [3:0] S_RESCLR = 4'd9;
    localparam logic [3:0] S_LINK = 4'd10;

    logic [63:0] mem [STORE_DEPTH];
    logic [63:0] rdata_reg;
    logic mem_we;
    logic [STORE_AW-1:0] mem_waddr;
    logic [63:0] mem_wdata;

    logic [3:0] state_reg;
    logic [STORE_AW-1:0] sweep_reg;
    logic [CNT_W-1:0] nff_reg;
    logic [47:0] va_reg, len_reg;
    logic [51:0] pa_reg;
    logic [11:0] prot_reg;
    logic ovw_reg, flush_reg;
    logic [36:0] done_reg;
    logic [2:0] st_reg;
    logic [47:0] fault_reg;
    logic [1:0] lvl_reg, depth_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [STORE_AW-1:0] pos_reg;
    logic out_valid_reg;
    rsp_t out_reg;

    logic [51:0] abase;
    logic [51:0] child_off;
    logic [FRAME_W-1:0] child;
    logic [8:0] idx;
    logic [47:0] chunk_sz;
    logic [51:0] new_ptr;

    assign abase = {pool_base[51:12], 12'd0};
    assign child_off = {rdata_reg[51:12], 12'd0} - abase;
    assign child = child_off[12 +: FRAME_W];
    assign new_ptr = abase + {{(40-CNT_W){1'b0}}, nff_reg, 12'd0};

    always_comb
    begin
        case (lvl_reg)
            2'd0: idx = va_reg[47:39];
            2'd1: idx = va_reg[38:30];
            2'd2: idx = va_reg[29:21];
            default: idx = va_reg[20:12];
        endcase
        case (depth_reg)
            2'd1: chunk_sz = 48'h40000000;
            2'd2: chunk_sz = 48'h200000;
            default: chunk_sz = 48'h1000;
        endcase
    end

    assign job_ready = state_reg == S_IDLE;
    assign rsp.valid = out_valid_reg;
    assign rsp.data = out_reg;

    always_comb
    begin
        mem_we = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = 64'd0;
        if (state_reg == S_RESCLR || state_reg == S_CLR)
        begin
            mem_we = 1'b1;
            mem_waddr = sweep_reg;
        end
        else if (state_reg == S_LINK)
        begin
            mem_we = 1'b1;
            mem_wdata = {12'd0, new_ptr[51:12], 12'h007};
        end
        else if (state_reg == S_LEAF)
        begin
            mem_we = 1'b1;
            mem_wdata = {12'd0, pa_reg[51:12], prot_reg | 12'h001
                         | ((depth_reg != 2'd3) ? 12'h080 : 12'h000)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[pos_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RESCLR;
            sweep_reg <= '0;
            nff_reg <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_OUT && (!out_valid_reg || rsp.ready))
            begin
                out_valid_reg <= 1'b1;
                out_reg <= {st_reg, done_reg, fault_reg, flush_reg};
            end
            else if (rsp.valid && rsp.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_RESCLR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == STORE_AW'(STORE_DEPTH - 1)) state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        va_reg <= job.req.virt_addr;
                        pa_reg <= job.req.phys_addr;
                        len_reg <= job.req.length_bytes;
                        prot_reg <= job.req.prot_bits;
                        ovw_reg <= job.req.ovw_en;
                        flush_reg <= 1'b0;
                        done_reg <= '0;
                        st_reg <= job.pre_status;
                        fault_reg <= '0;
                        state_reg <= job.pre_fault ? S_OUT : S_CHUNK;
                    end
                end
                S_CHUNK:
                begin
                    if (len_reg == 48'd0)
                    begin
                        st_reg <= ST_OK;
                        fault_reg <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        if (huge_en && va_reg[29:0] == 30'd0 && pa_reg[29:0] == 30'd0
                            && len_reg[47:30] != 18'd0)
                            depth_reg <= 2'd1;
                        else if (va_reg[20:0] == 21'd0 && pa_reg[20:0] == 21'd0
                                 && len_reg[47:21] != 27'd0)
                            depth_reg <= 2'd2;
                        else
                            depth_reg <= 2'd3;
                        lvl_reg <= 2'd0;
                        frame_reg <= '0;
                        state_reg <= S_INIT;
                    end
                end
                S_INIT:
                begin
                    pos_reg <= {frame_reg, idx};
                    state_reg <= S_RD;
                end
                S_RD: state_reg <= S_WAIT;
                S_WAIT: state_reg <= S_EVAL;
                S_EVAL:
                begin
                    if (lvl_reg == depth_reg)
                    begin
                        if (rdata_reg[0] && !ovw_reg)
                        begin
                            st_reg <= ST_MAPPED;
                            fault_reg <= va_reg;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            if (rdata_reg[0]) flush_reg <= 1'b1;
                            state_reg <= S_LEAF;
                        end
                    end
                    else if (rdata_reg[0] && rdata_reg[7] && lvl_reg != 2'd0)
                    begin
                        st_reg <= ST_HUGE;
                        fault_reg <= va_reg;
                        state_reg <= S_OUT;
                    end
                    else if (rdata_reg[0])
                    begin
                        frame_reg <= child;
                        lvl_reg <= lvl_reg + 1'b1;
                        state_reg <= S_INIT;
                    end
                    else if (nff_reg >= CNT_W'(TABLE_FRAMES))
                    begin
                        st_reg <= ST_POOL;
                        fault_reg <= va_reg;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        sweep_reg <= {nff_reg[FRAME_W-1:0], 9'd0};
                        state_reg <= S_CLR;
                    end
                end
                S_CLR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg[8:0] == 9'h1ff) state_reg <= S_LINK;
                end
                S_LINK:
                begin
                    frame_reg <= nff_reg[FRAME_W-1:0];
                    nff_reg <= nff_reg + 1'b1;
                    lvl_reg <= lvl_reg + 1'b1;
                    state_reg <= S_INIT;
                end
                S_LEAF:
                begin
                    done_reg <= done_reg + 1'b1;
                    va_reg <= va_reg + chunk_sz;
                    pa_reg <= pa_reg + {4'd0, chunk_sz};
                    len_reg <= len_reg - chunk_sz;
                    state_reg <= S_CHUNK;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || rsp.ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/page_table_range_mapper_core.sv =====
// top level of the page table range mapper
// channels: req (map request) and rsp (one result per request), valid/ready;
// configuration by cfg_we/cfg_index/cfg_data, register 0 enables 1G pages,
// register 1 is the physical base of the table frame pool
// after reset the whole store is swept clear, one entry a cycle, and no request
// is started until the sweep is done
// a two-entry queue holds classified requests ahead of the walker
// misaligned or empty requests skip the walk and go straight to the result register;
// each chunk reads one table entry per level (2 levels for 1G, 3 for 2M, 4 for 4K)
// in S_INIT, S_RD, S_WAIT and S_EVAL, then writes its leaf in S_LEAF; each newly
// taken table frame gets 512 clears through the single store write port and a link write
// one request is walked at a time
// a result waits in its output register while rsp.ready is low; the walker
// starts the next request meanwhile but holds its result until the old one leaves
`timescale 1ns / 1ps
module page_table_range_mapper_core
    import ptrm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ptrm_req_if.sink req,
    ptrm_rsp_if.source rsp,
    input  logic cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [51:0] cfg_data
);
    logic huge_en_reg;
    logic [51:0] pool_base_reg;
    logic job_valid, job_ready;
    job_t job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            huge_en_reg <= 1'b0;
            pool_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HUGE: huge_en_reg <= cfg_data[0];
                CFG_BASE: pool_base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    ptrm_front u_front (
        .clk(clk), .rst_n(rst_n), .req(req),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    ptrm_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .huge_en(huge_en_reg), .pool_base(pool_base_reg), .rsp(rsp)
    );

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.data.status <= ST_POOL)
        else $error("status out of range");
    a_ok_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.status == ST_OK) |-> rsp.data.fault_addr == 48'd0)
        else $error("fault address on success");
    a_misalign_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.data.status == ST_ADDR || rsp.data.status == ST_LEN))
        |-> (rsp.data.chunks_done == 37'd0 && !rsp.data.tlb_flush_needed))
        else $error("misaligned request reported work");
endmodule

// ===== test/ptrm_checker.sv =====
// checker for the page table range mapper: predicts each map result and compares
`timescale 1ns / 1ps
module ptrm_checker
    import ptrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ptrm_req_if         req,
    ptrm_rsp_if         rsp,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [51:0] cfg_data,
    output int          errors,
    output int          pending
);
    localparam bit [63:0] VA_MASK   = 64'h0000_FFFF_FFFF_FFFF;
    localparam bit [63:0] PA_MASK   = 64'h000F_FFFF_FFFF_FFFF;
    localparam bit [63:0] ADDR_BITS = 64'h000F_FFFF_FFFF_F000;
    localparam bit [63:0] SZ_4K     = 64'h1000;
    localparam bit [63:0] SZ_2M     = 64'h20_0000;
    localparam bit [63:0] SZ_1G     = 64'h4000_0000;

    bit [63:0] pte_store [int];
    int        free_frame;
    bit        huge_en;
    bit [63:0] pool_base;
    rsp_t      result_q [$];

    function automatic bit [63:0] peek(int pos);
        return pte_store.exists(pos) ? pte_store[pos] : 64'd0;
    endfunction

    function automatic int child(bit [63:0] e);
        bit [63:0] off;
        off = ((e & ADDR_BITS) - (pool_base & ADDR_BITS)) & PA_MASK;
        return int'(off[17:12]);
    endfunction

    function automatic int slot(int frame, bit [63:0] va, int shift);
        bit [63:0] idx;
        idx = (va >> shift) & 64'h1FF;
        return frame * 512 + int'(idx);
    endfunction

    task automatic link_table(input int pos, output bit ok);
        bit [63:0] fa;
        bit [63:0] cur;
        ok = 1'b1;
        cur = peek(pos);
        if (!cur[0])
        begin
            if (free_frame >= TABLE_FRAMES)
                ok = 1'b0;
            else
            begin
                for (int i = 0; i < 512; i++)
                    pte_store.delete(free_frame * 512 + i);
                fa = ((pool_base & ADDR_BITS) + 64'(free_frame) * SZ_4K) & ADDR_BITS;
                pte_store[pos] = fa | 64'h7;
                free_frame++;
            end
        end
    endtask

    task automatic walk(input bit [63:0] va, input int depth, output bit [2:0] st,
                        output int leaf);
        int        pos;
        bit        ok;
        bit [63:0] e;
        leaf = 0;
        st = ST_OK;
        pos = slot(0, va, 39);
        link_table(pos, ok);
        if (!ok)
        begin
            st = ST_POOL;
            return;
        end
        pos = slot(child(peek(pos)), va, 30);
        if (depth == 1)
        begin
            leaf = pos;
            return;
        end
        e = peek(pos);
        if (e[0] && e[7])
        begin
            st = ST_HUGE;
            return;
        end
        link_table(pos, ok);
        if (!ok)
        begin
            st = ST_POOL;
            return;
        end
        pos = slot(child(peek(pos)), va, 21);
        if (depth == 2)
        begin
            leaf = pos;
            return;
        end
        e = peek(pos);
        if (e[0] && e[7])
        begin
            st = ST_HUGE;
            return;
        end
        link_table(pos, ok);
        if (!ok)
        begin
            st = ST_POOL;
            return;
        end
        leaf = slot(child(peek(pos)), va, 12);
    endtask

    task automatic map_range(input req_t r, output rsp_t o);
        bit [63:0] va, pa, len, chunk, fault, cnt, e;
        bit [2:0]  st;
        bit        flush;
        int        depth, leaf;
        va = 64'(r.virt_addr);
        pa = 64'(r.phys_addr);
        len = 64'(r.length_bytes);
        st = ST_OK;
        cnt = 0;
        fault = 0;
        flush = 0;
        if (va[11:0] != 0 || pa[11:0] != 0)
            st = ST_ADDR;
        else if (len[11:0] != 0)
            st = ST_LEN;
        else
        begin
            while (len > 0)
            begin
                if (huge_en && va[29:0] == 0 && pa[29:0] == 0 && len >= SZ_1G)
                begin
                    chunk = SZ_1G;
                    depth = 1;
                end
                else if (va[20:0] == 0 && pa[20:0] == 0 && len >= SZ_2M)
                begin
                    chunk = SZ_2M;
                    depth = 2;
                end
                else
                begin
                    chunk = SZ_4K;
                    depth = 3;
                end
                walk(va, depth, st, leaf);
                e = peek(leaf);
                if (st == ST_OK && e[0])
                begin
                    if (!r.ovw_en)
                        st = ST_MAPPED;
                    else
                        flush = 1'b1;
                end
                if (st != ST_OK)
                begin
                    fault = va;
                    break;
                end
                pte_store[leaf] = pa | 64'h1 | 64'(r.prot_bits) |
                                  (depth != 3 ? 64'h80 : 64'h0);
                cnt++;
                va = (va + chunk) & VA_MASK;
                pa = (pa + chunk) & PA_MASK;
                len = len - chunk;
            end
        end
        o.status = st;
        o.chunks_done = cnt[36:0];
        o.fault_addr = fault[47:0];
        o.tlb_flush_needed = flush;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want, got;
        if (!rst_n)
        begin
            pte_store.delete();
            free_frame = 1;
            huge_en = 1'b0;
            pool_base = 0;
            result_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_HUGE)
                    huge_en = cfg_data[0];
                else
                    pool_base = 64'(cfg_data) & PA_MASK;
            end
            if (rsp.valid && rsp.ready)
            begin
                got = rsp.data;
                if (result_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result transaction %p", got);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got.status !== want.status || got.chunks_done !== want.chunks_done ||
                        got.fault_addr !== want.fault_addr ||
                        got.tlb_flush_needed !== want.tlb_flush_needed)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $write("mismatch: expected st=%0d chunks=%0d fault=%h flush=%0d,",
                                   want.status, want.chunks_done, want.fault_addr,
                                   want.tlb_flush_needed);
                            $display(" got st=%0d chunks=%0d fault=%h flush=%0d",
                                     got.status, got.chunks_done, got.fault_addr,
                                     got.tlb_flush_needed);
                        end
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                map_range(req.data, want);
                result_q.push_back(want);
            end
            pending = result_q.size();
        end
    end
endmodule

// ===== test/tb_page_table_range_mapper_core.sv =====
// testbench top for the page table range mapper: stimulus, config phases and verdict
`timescale 1ns / 1ps
module tb_page_table_range_mapper_core;
    import ptrm_pkg::*;

    localparam logic [51:0] BASE_MAX = 52'hF_FFFF_FFFF_F000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [51:0] cfg_data;
    int          errors;
    int          pending;
    bit          quiet;
    bit          hold_go;
    bit          huge_on;

    ptrm_req_if req ();
    ptrm_rsp_if rsp ();

    page_table_range_mapper_core uut (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ptrm_checker chk (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #60_000_000;
        $display("tb_page_table_range_mapper_core failed");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                rsp.ready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_go = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(negedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
                repeat ($urandom_range(0, 20)) @(negedge clk);
            end
        end
    end

    task automatic send(input req_t r);
        @(negedge clk);
        req.valid <= 1'b1;
        req.data <= r;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 14) - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        req.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [51:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input bit huge, input logic [51:0] base);
        drain();
        write_reg(CFG_HUGE, {51'd0, huge});
        write_reg(CFG_BASE, base);
        huge_on = huge;
    endtask

    function automatic req_t mk(input logic [47:0] va, input logic [51:0] pa,
                                input logic [47:0] len, input logic [11:0] prot,
                                input logic ovw);
        req_t r;
        r.virt_addr = va;
        r.phys_addr = pa;
        r.length_bytes = len;
        r.prot_bits = prot;
        r.ovw_en = ovw;
        return r;
    endfunction

    function automatic logic [47:0] pick_va(input int level);
        logic [8:0] l4, l3, l2, l1;
        case ($urandom_range(0, 3))
            0: l4 = 9'd0;
            1: l4 = 9'd1;
            2: l4 = 9'd255;
            default: l4 = 9'd511;
        endcase
        case ($urandom_range(0, 2))
            0: l3 = 9'd0;
            1: l3 = 9'd1;
            default: l3 = 9'd511;
        endcase
        l2 = ($urandom_range(0, 4) == 4) ? 9'd511 : 9'($urandom_range(0, 3));
        l1 = 9'($urandom_range(0, 511));
        if (level <= 2)
            l1 = 9'd0;
        if (level == 1)
            l2 = 9'd0;
        return {l4, l3, l2, l1, 12'd0};
    endfunction

    function automatic req_t random_req();
        logic [51:0] pa;
        logic [47:0] len;
        logic [47:0] va;
        int          kind;
        pa = 52'({$urandom, $urandom}) & 52'hF_FFFF_FFFF_F000;
        kind = $urandom_range(0, 9);
        if (kind == 9 && !huge_on)
            kind = 6;
        if (kind <= 1)
        begin
            // misaligned noise over full field widths
            va = 48'({$urandom, $urandom});
            pa = 52'({$urandom, $urandom});
            len = 48'({$urandom, $urandom});
            case ($urandom_range(0, 2))
                0: va[11:0] = 12'($urandom_range(1, 4095));
                1: pa[11:0] = 12'($urandom_range(1, 4095));
                default:
                begin
                    va[11:0] = 12'd0;
                    pa[11:0] = 12'd0;
                    len[11:0] = 12'($urandom_range(1, 4095));
                end
            endcase
            return mk(va, pa, len, 12'($urandom), 1'($urandom));
        end
        if (kind <= 5)
        begin
            len = 48'($urandom_range(0, 8)) << 12;
            return mk(pick_va(3), pa, len, 12'($urandom), 1'($urandom));
        end
        if (kind <= 8)
        begin
            pa[20:0] = 21'd0;
            len = (48'($urandom_range(1, 2)) << 21) + (48'($urandom_range(0, 2)) << 12);
            return mk(pick_va(2), pa, len, 12'($urandom), 1'($urandom));
        end
        pa[29:0] = 30'd0;
        len = (48'($urandom_range(1, 2)) << 30) + (48'($urandom_range(0, 1)) << 21);
        return mk(pick_va(1), pa, len, 12'($urandom), 1'($urandom));
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
        begin
            send(random_req());
            sender_gap();
        end
    endtask

    initial
    begin
        req.valid = 1'b0;
        req.data = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_HUGE;
        cfg_data = '0;
        quiet = 1'b0;
        hold_go = 1'b0;
        huge_on = 1'b0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_config(1'b0, 52'd0);
        send(mk(48'd0, 52'd0, 48'd0, 12'd0, 1'b0));
        send(mk(48'h1001, 52'h2000, 48'h1000, 12'h003, 1'b0));
        send(mk(48'h1000, 52'h2fff, 48'h1000, 12'h003, 1'b0));
        send(mk(48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 12'hFFF, 1'b1));
        send(mk(48'h3000, 52'h4000, 48'h1801, 12'h002, 1'b0));
        send(mk(48'h5000, 52'h6000, 48'h1000, 12'h002, 1'b0));
        send(mk(48'h5000, 52'h7000, 48'h1000, 12'h002, 1'b0));
        send(mk(48'h5000, 52'h8000, 48'h2000, 12'hFFF, 1'b1));
        send(mk(48'h40_0000, 52'h20_0000, 48'h20_0000, 12'h006, 1'b0));
        send(mk(48'h40_1000, 52'h9000, 48'h1000, 12'h002, 1'b1));
        send(mk(48'h0, 52'h60_0000, 48'h20_0000, 12'h002, 1'b1));
        send(mk(48'hFFFF_FFFF_F000, 52'hF_FFFF_FFFF_F000, 48'h2000, 12'hFFE, 1'b0));
        send(mk(48'h7F_C000_0000, 52'hF_FFFF_C000_0000 & 52'hF_FFFF_FFE0_0000, 48'h40_3000,
                12'h080, 1'b0));
        random_phase(170);

        set_config(1'b1, BASE_MAX);
        send(mk(48'h80_4000_0000, 52'h4000_0000, 48'h4000_0000, 12'h003, 1'b0));
        send(mk(48'h80_4000_1000, 52'h1000, 48'h1000, 12'h003, 1'b0));
        send(mk(48'h80_4000_0000, 52'h8000_0000, 48'h4020_0000, 12'h003, 1'b1));
        send(mk(48'h80_4000_0000, 52'h8000_0000, 48'h4000_0000, 12'h003, 1'b0));
        send(mk(48'h0, 52'h0, 48'h4000_0000, 12'h001, 1'b1));
        random_phase(100);
        // long result stall while requests keep coming
        hold_go = 1'b1;
        for (int i = 0; i < 12; i++)
            send(random_req());
        random_phase(70);

        set_config(1'b0, 52'({$urandom, $urandom}));
        random_phase(170);

        set_config(1'b1, 52'd0);
        quiet = 1'b1;
        random_phase(160);

        drain();
        if (errors == 0 && pending == 0)
            $display("tb_page_table_range_mapper_core passed");
        else
            $display("tb_page_table_range_mapper_core failed");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/ptrm_pkg.sv
hdl/ptrm_req_if.sv
hdl/ptrm_rsp_if.sv
hdl/ptrm_front.sv
hdl/ptrm_back.sv
hdl/page_table_range_mapper_core.sv
test/ptrm_checker.sv
test/tb_page_table_range_mapper_core.sv
